### rtl/gcd_pkg.sv
// Shared types and constants of the glyph cache directory.
// No dependencies; used by the top level and the RAM wrapper users.
`default_nettype none
package gcd_pkg;

    localparam int unsigned ENTRIES_DEF  = 256;
    localparam int unsigned KEY_W        = 16;
    localparam int unsigned TIME_W       = 16;
    localparam int unsigned CNT_W        = 16;
    localparam int unsigned SIDE_W       = 8;
    localparam int unsigned CFG_IDX_W    = 8;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [CNT_W-1:0]  COUNT_MAX    = 16'hFFFF;
    localparam logic [TIME_W-1:0] START_AGE    = 16'd64;
    localparam logic [SIDE_W-1:0] MAX_SIDE_RST = 8'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIDE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_TH   = 8'd1;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [2:0] ST_HIT    = 3'd0;
    localparam logic [2:0] ST_MISS   = 3'd1;
    localparam logic [2:0] ST_INS    = 3'd2;
    localparam logic [2:0] ST_INS_EV = 3'd3;
    localparam logic [2:0] ST_BIG    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BS,
        S_BS_CMP,
        S_HIT_RD,
        S_HIT_WR,
        S_SC_RD1,
        S_SC_RD2,
        S_SC_CMP,
        S_SC_END,
        S_EV_RD,
        S_EV_WR,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### rtl/gcd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module gcd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/glyph_cache_directory_lfu_aged_core.sv
// Glyph cache directory: sorted key store with binary search and aged LFU eviction.
// Depends on gcd_pkg and gcd_ram.
//
// Usage:
//  - Request channel (i_in_valid/o_in_ready) carries opcode, char_code, now_time
//    and the glyph size; one transfer gives exactly one result transfer on the
//    result channel (o_out_valid/i_out_ready): status, slot_index, evicted_code.
//  - One request is worked at a time. A lookup runs a binary search over the n stored
//    codes; each probe is a directory RAM read, then a compare of the registered
//    read data. A hit adds a slot RAM read and write for the use count update.
//  - An insert moves each directory entry above its position up one place (a read,
//    then a write) and then writes the new entry. On a full directory the eviction
//    scan reads each scanned entry (directory read, then slot RAM read) once per
//    pass, one pass per halving of the age threshold, then moves entries down.
//  - The result sits in an output register; a new request is taken while it
//    waits. If the receiver stalls, a second finished result holds the
//    sequencer until the first is taken.
//  - Config writes (i_cfg_*) are always accepted; write them only while idle.
//  - Reset (synchronous, active low) empties the directory; RAM contents are
//    not cleared, only entries below the fill count are ever read.
`default_nettype none
module glyph_cache_directory_lfu_aged_core #(
    parameter int unsigned ENTRIES = gcd_pkg::ENTRIES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_opcode,
    input  wire logic [gcd_pkg::KEY_W-1:0]      i_char_code,
    input  wire logic [gcd_pkg::TIME_W-1:0]     i_now_time,
    input  wire logic [gcd_pkg::SIDE_W-1:0]     i_glyph_width,
    input  wire logic [gcd_pkg::SIDE_W-1:0]     i_glyph_height,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [2:0]                          o_status,
    output logic [7:0]                          o_slot_index,
    output logic [gcd_pkg::KEY_W-1:0]           o_evicted_code,
    // config write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned AW  = $clog2(ENTRIES);
    localparam int unsigned CW  = AW + 1;
    localparam int unsigned KW  = gcd_pkg::KEY_W;
    localparam int unsigned DW  = KW + AW;                               // {key, slot}
    localparam int unsigned SLW = gcd_pkg::CNT_W + gcd_pkg::TIME_W;      // {count, time}
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    // directory RAM: sorted codes and their slots
    logic          dir_we;
    logic [AW-1:0] dir_waddr, dir_raddr;
    logic [DW-1:0] dir_wdata, dir_rdata;
    // slot RAM: use count and load time
    logic           sl_we;
    logic [AW-1:0]  sl_waddr, sl_raddr;
    logic [SLW-1:0] sl_wdata, sl_rdata;

    gcd_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_dir_ram (
        .i_clk  (i_clk),
        .i_we   (dir_we),
        .i_waddr(dir_waddr),
        .i_wdata(dir_wdata),
        .i_raddr(dir_raddr),
        .o_rdata(dir_rdata)
    );

    gcd_ram #(.WIDTH(SLW), .DEPTH(ENTRIES)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (sl_we),
        .i_waddr(sl_waddr),
        .i_wdata(sl_wdata),
        .i_raddr(sl_raddr),
        .o_rdata(sl_rdata)
    );

    logic [KW-1:0]                 d_key;
    logic [AW-1:0]                 d_slot;
    logic [gcd_pkg::CNT_W-1:0]     s_cnt;
    logic [gcd_pkg::TIME_W-1:0]    s_tim;
    assign d_key  = dir_rdata[DW-1 -: KW];
    assign d_slot = dir_rdata[AW-1:0];
    assign s_cnt  = sl_rdata[SLW-1 -: gcd_pkg::CNT_W];
    assign s_tim  = sl_rdata[gcd_pkg::TIME_W-1:0];

    // control state
    gcd_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [AW-1:0] r_freed_slot, n_freed_slot;
    logic          r_freed_valid, n_freed_valid;
    logic [AW-1:0] r_lep, n_lep;
    logic          r_out_valid, n_out_valid;
    logic [gcd_pkg::SIDE_W-1:0] r_max_side;
    logic [gcd_pkg::TIME_W-1:0] r_age_th;

    // working registers of one request
    logic                       r_op, n_op;
    logic [KW-1:0]              r_code, n_code;
    logic [gcd_pkg::TIME_W-1:0] r_now, n_now;
    logic [gcd_pkg::SIDE_W-1:0] r_w, n_w, r_h, n_h;
    logic [CW-1:0]              r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [CW-1:0]              r_pos, n_pos, r_j, n_j, r_i, n_i;
    logic                       r_found, n_found;
    logic [AW-1:0]              r_hit_slot, n_hit_slot;
    logic                       r_evict, n_evict;
    logic [AW-1:0]              r_start, n_start;
    logic [gcd_pkg::TIME_W-1:0] r_th, n_th;
    logic [gcd_pkg::CNT_W-1:0]  r_best, n_best;
    logic                       r_vfound, n_vfound;
    logic [AW-1:0]              r_vic_idx, n_vic_idx, r_vic_slot, n_vic_slot;
    logic [KW-1:0]              r_vic_key, n_vic_key;
    logic [KW-1:0]              r_cur_key, n_cur_key;
    logic [AW-1:0]              r_cur_slot, n_cur_slot;
    logic [KW-1:0]              r_st_key, n_st_key;
    logic [AW-1:0]              r_st_slot, n_st_slot;
    logic [KW-1:0]              r_ev_code, n_ev_code;
    // finished result and output register
    logic [2:0]    r_res_status, n_res_status;
    logic [AW-1:0] r_res_slot, n_res_slot;
    logic [KW-1:0] r_res_ev, n_res_ev;
    logic [2:0]    r_o_status, n_o_status;
    logic [AW-1:0] r_o_slot, n_o_slot;
    logic [KW-1:0] r_o_ev, n_o_ev;

    logic                       in_acc;
    logic [CW-1:0]              mid;
    logic [gcd_pkg::TIME_W-1:0] age;
    logic [AW-1:0]              sel_idx, sel_slot, take;
    logic [KW-1:0]              sel_key;

    assign o_in_ready     = (r_state == gcd_pkg::S_IDLE);
    assign in_acc         = i_in_valid & o_in_ready;
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_slot_index   = 8'(r_o_slot);
    assign o_evicted_code = r_o_ev;

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign age      = r_now - s_tim;
    assign sel_idx  = r_vfound ? r_vic_idx  : r_start;
    assign sel_slot = r_vfound ? r_vic_slot : r_st_slot;
    assign sel_key  = r_vfound ? r_vic_key  : r_st_key;

    always_comb begin
        n_state = r_state;       n_total = r_total;     n_fresh = r_fresh;
        n_freed_slot = r_freed_slot; n_freed_valid = r_freed_valid; n_lep = r_lep;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_op = r_op; n_code = r_code; n_now = r_now; n_w = r_w; n_h = r_h;
        n_lo = r_lo; n_hi = r_hi; n_mid = r_mid; n_pos = r_pos; n_j = r_j; n_i = r_i;
        n_found = r_found; n_hit_slot = r_hit_slot; n_evict = r_evict;
        n_start = r_start; n_th = r_th; n_best = r_best; n_vfound = r_vfound;
        n_vic_idx = r_vic_idx; n_vic_slot = r_vic_slot; n_vic_key = r_vic_key;
        n_cur_key = r_cur_key; n_cur_slot = r_cur_slot;
        n_st_key = r_st_key; n_st_slot = r_st_slot; n_ev_code = r_ev_code;
        n_res_status = r_res_status; n_res_slot = r_res_slot; n_res_ev = r_res_ev;
        n_o_status = r_o_status; n_o_slot = r_o_slot; n_o_ev = r_o_ev;
        take = '0;
        dir_we = 1'b0; dir_waddr = '0; dir_wdata = '0; dir_raddr = '0;
        sl_we = 1'b0;  sl_waddr = '0;  sl_wdata = '0;  sl_raddr = '0;

        unique case (r_state)
            gcd_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op = i_opcode; n_code = i_char_code; n_now = i_now_time;
                    n_w = i_glyph_width; n_h = i_glyph_height;
                    n_lo = '0; n_hi = r_total; n_found = 1'b0; n_evict = 1'b0;
                    n_state = gcd_pkg::S_BS;
                end
            end
            gcd_pkg::S_BS: begin
                if (r_lo < r_hi) begin
                    dir_raddr = mid[AW-1:0];
                    n_mid     = mid;
                    n_state   = gcd_pkg::S_BS_CMP;
                end else begin
                    n_pos = r_lo;
                    if (r_found) begin
                        n_state = gcd_pkg::S_HIT_RD;
                    end else if (r_op == gcd_pkg::OP_LOOKUP) begin
                        n_res_status = gcd_pkg::ST_MISS; n_res_slot = '0; n_res_ev = '0;
                        n_state = gcd_pkg::S_DONE;
                    end else if (r_w > r_max_side || r_h > r_max_side) begin
                        n_res_status = gcd_pkg::ST_BIG; n_res_slot = '0; n_res_ev = '0;
                        n_state = gcd_pkg::S_DONE;
                    end else if (r_total == FULL) begin
                        // scan starts one past the last evicted position, wrapping
                        n_start  = (r_lep == LAST) ? '0 : r_lep + AW'(1);
                        n_i      = (r_lep == LAST) ? '0 : {1'b0, r_lep} + CW'(1);
                        n_th     = r_age_th;
                        n_best   = gcd_pkg::COUNT_MAX;
                        n_vfound = 1'b0;
                        n_evict  = 1'b1;
                        n_state  = gcd_pkg::S_SC_RD1;
                    end else begin
                        n_j     = r_total;
                        n_state = gcd_pkg::S_INS_RD;
                    end
                end
            end
            gcd_pkg::S_BS_CMP: begin
                if (d_key < r_code) n_lo = r_mid + CW'(1);
                else                n_hi = r_mid;
                // keys are unique: an equal probe is the lower bound
                if (d_key == r_code) begin
                    n_found = 1'b1; n_hit_slot = d_slot;
                end
                n_state = gcd_pkg::S_BS;
            end
            gcd_pkg::S_HIT_RD: begin
                sl_raddr = r_hit_slot;
                n_state  = gcd_pkg::S_HIT_WR;
            end
            gcd_pkg::S_HIT_WR: begin
                sl_we    = 1'b1;
                sl_waddr = r_hit_slot;
                sl_wdata = {(s_cnt == gcd_pkg::COUNT_MAX) ? s_cnt : s_cnt + 16'd1, s_tim};
                n_res_status = gcd_pkg::ST_HIT; n_res_slot = r_hit_slot; n_res_ev = '0;
                n_state = gcd_pkg::S_DONE;
            end
            gcd_pkg::S_SC_RD1: begin
                if (r_i < FULL) begin
                    dir_raddr = r_i[AW-1:0];
                    n_state   = gcd_pkg::S_SC_RD2;
                end else begin
                    n_state = gcd_pkg::S_SC_END;
                end
            end
            gcd_pkg::S_SC_RD2: begin
                n_cur_key  = d_key;
                n_cur_slot = d_slot;
                sl_raddr   = d_slot;
                n_state    = gcd_pkg::S_SC_CMP;
            end
            gcd_pkg::S_SC_CMP: begin
                if (r_i[AW-1:0] == r_start) begin
                    n_st_key = r_cur_key; n_st_slot = r_cur_slot;
                end
                // lowest count among old-enough entries, first wins a tie
                if (age >= r_th && s_cnt < r_best) begin
                    n_best = s_cnt; n_vfound = 1'b1;
                    n_vic_idx = r_i[AW-1:0]; n_vic_key = r_cur_key; n_vic_slot = r_cur_slot;
                end
                n_i     = r_i + CW'(1);
                n_state = gcd_pkg::S_SC_RD1;
            end
            gcd_pkg::S_SC_END: begin
                if (r_vfound || r_th == '0) begin
                    n_lep = sel_idx; n_freed_slot = sel_slot; n_freed_valid = 1'b1;
                    n_ev_code = sel_key;
                    n_pos = ({1'b0, sel_idx} < r_pos) ? r_pos - CW'(1) : r_pos;
                    n_j   = {1'b0, sel_idx};
                    n_state = gcd_pkg::S_EV_RD;
                end else begin
                    n_th = r_th >> 1; n_i = {1'b0, r_start};
                    n_best = gcd_pkg::COUNT_MAX;
                    n_state = gcd_pkg::S_SC_RD1;
                end
            end
            gcd_pkg::S_EV_RD: begin
                if (r_j + CW'(1) < FULL) begin
                    dir_raddr = AW'(r_j + CW'(1));
                    n_state   = gcd_pkg::S_EV_WR;
                end else begin
                    n_total = r_total - CW'(1);
                    n_j     = r_total - CW'(1);
                    n_state = gcd_pkg::S_INS_RD;
                end
            end
            gcd_pkg::S_EV_WR: begin
                dir_we = 1'b1; dir_waddr = r_j[AW-1:0]; dir_wdata = dir_rdata;
                n_j = r_j + CW'(1);
                n_state = gcd_pkg::S_EV_RD;
            end
            gcd_pkg::S_INS_RD: begin
                if (r_j > r_pos) begin
                    dir_raddr = AW'(r_j - CW'(1));
                    n_state   = gcd_pkg::S_INS_WR;
                end else begin
                    n_state = gcd_pkg::S_INS_PUT;
                end
            end
            gcd_pkg::S_INS_WR: begin
                dir_we = 1'b1; dir_waddr = r_j[AW-1:0]; dir_wdata = dir_rdata;
                n_j = r_j - CW'(1);
                n_state = gcd_pkg::S_INS_RD;
            end
            gcd_pkg::S_INS_PUT: begin
                if (r_freed_valid) begin
                    take = r_freed_slot; n_freed_valid = 1'b0;
                end else if (r_fresh < FULL) begin
                    take = r_fresh[AW-1:0]; n_fresh = r_fresh + CW'(1);
                end
                dir_we = 1'b1; dir_waddr = r_pos[AW-1:0]; dir_wdata = {r_code, take};
                sl_we  = 1'b1; sl_waddr  = take; sl_wdata = {16'd1, r_now};
                n_total = r_total + CW'(1);
                n_res_status = r_evict ? gcd_pkg::ST_INS_EV : gcd_pkg::ST_INS;
                n_res_slot   = take;
                n_res_ev     = r_evict ? r_ev_code : '0;
                n_state = gcd_pkg::S_DONE;
            end
            gcd_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status = r_res_status; n_o_slot = r_res_slot; n_o_ev = r_res_ev;
                    n_state = gcd_pkg::S_IDLE;
                end
            end
            default: n_state = gcd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcd_pkg::S_IDLE;
            r_total <= '0; r_fresh <= '0; r_freed_slot <= '0; r_freed_valid <= 1'b0;
            r_lep <= '0; r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total; r_fresh <= n_fresh; r_freed_slot <= n_freed_slot;
            r_freed_valid <= n_freed_valid; r_lep <= n_lep; r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_side <= gcd_pkg::MAX_SIDE_RST;
            r_age_th   <= gcd_pkg::START_AGE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gcd_pkg::CFG_MAX_SIDE: r_max_side <= i_cfg_data[gcd_pkg::SIDE_W-1:0];
                gcd_pkg::CFG_AGE_TH:   r_age_th   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_code <= n_code; r_now <= n_now; r_w <= n_w; r_h <= n_h;
        r_lo <= n_lo; r_hi <= n_hi; r_mid <= n_mid; r_pos <= n_pos; r_j <= n_j; r_i <= n_i;
        r_found <= n_found; r_hit_slot <= n_hit_slot; r_evict <= n_evict;
        r_start <= n_start; r_th <= n_th; r_best <= n_best; r_vfound <= n_vfound;
        r_vic_idx <= n_vic_idx; r_vic_slot <= n_vic_slot; r_vic_key <= n_vic_key;
        r_cur_key <= n_cur_key; r_cur_slot <= n_cur_slot;
        r_st_key <= n_st_key; r_st_slot <= n_st_slot; r_ev_code <= n_ev_code;
        r_res_status <= n_res_status; r_res_slot <= n_res_slot; r_res_ev <= n_res_ev;
        r_o_status <= n_o_status; r_o_slot <= n_o_slot; r_o_ev <= n_o_ev;
    end

    // fill count never passes the directory depth
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= FULL) else $error("directory fill count overflow");

    // a freed slot is always reused by the insert that freed it
    a_freed_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gcd_pkg::S_IDLE |-> !r_freed_valid) else $error("freed slot left pending");

    // the final insert write only happens with room in the directory
    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gcd_pkg::S_INS_PUT |-> r_total < FULL) else $error("insert into full directory");

    // an accepted request starts with the binary search
    a_start_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == gcd_pkg::S_BS) else $error("request not started");

endmodule
`default_nettype wire
